// File: rtl/qrmpw_pkg.sv
// ----------------------------------------------------------------------------
// qrmpw_pkg
// Types and constants shared by the qr module placement walker files.
// ----------------------------------------------------------------------------
package qrmpw_pkg;

  localparam int SIDE       = 21;
  localparam int CELLS      = SIDE * SIDE;
  localparam int IDX_W      = 9;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int STEP_W     = 10;
  localparam int MAX_STEPS  = 2 * CELLS;
  localparam int TIMING_COL = 6;
  localparam int STRIP_COL  = 7;

  // row = (index * DIV_MUL) >> DIV_SHIFT, exact for every 9-bit index
  localparam int DIV_SHIFT  = 14;
  localparam int DIV_MUL    = ((1 << DIV_SHIFT) + SIDE - 1) / SIDE;
  localparam int PROD_W     = IDX_W + DIV_SHIFT - 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_REJECT = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic prep;
    logic advance;
    logic load;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic find_ok;
    logic find_bad;
    logic free;
    logic stop;
    logic slot_free;
  } sts_t;

endpackage

// File: rtl/qrmpw_in_if.sv
// ----------------------------------------------------------------------------
// qrmpw_in_if
// Input channel: write or find word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrmpw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [qrmpw_pkg::IDX_W-1:0] module_index;
  logic                        module_value;

  modport source (output valid, output operation, output module_index,
                  output module_value, input ready);
  modport sink   (input valid, input operation, input module_index,
                  input module_value, output ready);
endinterface

// File: rtl/qrmpw_out_if.sv
// ----------------------------------------------------------------------------
// qrmpw_out_if
// Result channel: found module index and no-free flag with valid/ready.
// ----------------------------------------------------------------------------
interface qrmpw_out_if;
  logic                        valid;
  logic                        ready;
  logic [qrmpw_pkg::IDX_W-1:0] free_index;
  logic                        no_free;

  modport source (output valid, output free_index, output no_free, input ready);
  modport sink   (input valid, input free_index, input no_free, output ready);
endinterface

// File: rtl/qr_module_placement_walker_unit.sv
// ----------------------------------------------------------------------------
// qr_module_placement_walker_unit
// Occupancy bitmap of a 21x21 qr symbol with a zigzag free-module finder.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every module (one module
// per cycle) with in ready low. A write word is stored as it is taken. A
// find word starts the read and splits off the row, then the column, then
// steps over each reserved module in placement order, one read at a time,
// since the occupancy memory has a single read port; the result goes into
// the output register once that is free. An out-of-range find skips the
// walk and answers no_free. A new word is taken while a result still waits.
module qr_module_placement_walker_unit (
  input logic         clk,
  input logic         rst_n,
  qrmpw_in_if.sink    in_chan,
  qrmpw_out_if.source out_chan
);

  qrmpw_pkg::cmd_t cmd;
  qrmpw_pkg::sts_t sts;

  qrmpw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qrmpw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_chan.operation),
    .in_module_index (in_chan.module_index),
    .in_module_value (in_chan.module_value),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_free_index  (out_chan.free_index),
    .out_no_free     (out_chan.no_free),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: rtl/qrmpw_ctrl.sv
// ----------------------------------------------------------------------------
// qrmpw_ctrl
// Sequencer for the clearing pass, item intake and the placement walk.
// ----------------------------------------------------------------------------
module qrmpw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  qrmpw_pkg::sts_t sts,
  output qrmpw_pkg::cmd_t cmd
);

  qrmpw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrmpw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      qrmpw_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = qrmpw_pkg::ST_IDLE;
      end
      qrmpw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.find_ok) state_nxt = qrmpw_pkg::ST_PREP;
          else if (sts.find_bad) state_nxt = qrmpw_pkg::ST_REJECT;
        end
      end
      qrmpw_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = qrmpw_pkg::ST_WALK;
      end
      qrmpw_pkg::ST_WALK: begin
        if (sts.free || sts.stop) begin
          if (sts.slot_free) begin
            cmd.load  = 1'b1;
            cmd.found = sts.free;
            state_nxt = qrmpw_pkg::ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      qrmpw_pkg::ST_REJECT: begin
        if (sts.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = qrmpw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qrmpw_pkg::ST_CLEAR;
    endcase
  end

endmodule

// File: rtl/qrmpw_dp.sv
// ----------------------------------------------------------------------------
// qrmpw_dp
// Occupancy memory, walk position registers, zigzag step and result register.
// ----------------------------------------------------------------------------
module qrmpw_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_operation,
  input  logic [qrmpw_pkg::IDX_W-1:0] in_module_index,
  input  logic                        in_module_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [qrmpw_pkg::IDX_W-1:0] out_free_index,
  output logic                        out_no_free,
  input  qrmpw_pkg::cmd_t             cmd,
  output qrmpw_pkg::sts_t             sts
);

  localparam int IW = qrmpw_pkg::IDX_W;
  localparam int RW = qrmpw_pkg::ROW_W;
  localparam int CW = qrmpw_pkg::COL_W;
  localparam int SW = qrmpw_pkg::STEP_W;
  localparam int PW = qrmpw_pkg::PROD_W;

  logic mem_r [qrmpw_pkg::CELLS];
  logic rd_data_r;

  logic [IW-1:0] clr_cnt_r;
  logic [IW-1:0] pos_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [SW-1:0] steps_r;
  logic          moving_up_r;
  logic          out_valid_r;
  logic [IW-1:0] res_idx_r;
  logic          res_nf_r;

  logic          in_range;
  logic          wr_en, wr_data, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] prod;

  logic          left_col, turn, step_fail, toggle;
  logic [IW:0]   pos_ext, pos_nxt;
  logic [RW-1:0] row_nxt;
  logic [CW-1:0] col_nxt;

  assign in_range = in_module_index < IW'(qrmpw_pkg::CELLS);
  assign prod     = PW'(in_module_index) * PW'(qrmpw_pkg::DIV_MUL);

  // memory ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 1'b0;
    rd_en   = 1'b0;
    rd_addr = in_module_index;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.take && in_range) begin
      if (in_operation == qrmpw_pkg::OP_WRITE) begin
        wr_en   = 1'b1;
        wr_addr = in_module_index;
        wr_data = in_module_value;
      end else begin
        rd_en = 1'b1;
      end
    end else if (cmd.advance && !sts.stop) begin
      rd_en   = 1'b1;
      rd_addr = pos_nxt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  // zigzag step
  always_comb begin
    pos_ext   = {1'b0, pos_r};
    left_col  = col_r[0] != (col_r < CW'(qrmpw_pkg::STRIP_COL));
    turn      = 1'b0;
    step_fail = 1'b0;
    toggle    = 1'b0;
    pos_nxt   = pos_ext - 1'b1;
    row_nxt   = row_r;
    col_nxt   = col_r - 1'b1;
    if (col_r != CW'(qrmpw_pkg::TIMING_COL) && left_col) begin
      turn = (row_r == '0 && moving_up_r) ||
             (row_r == RW'(qrmpw_pkg::SIDE - 1) && !moving_up_r);
      if (turn) begin
        if (col_r == '0) step_fail = 1'b1;
        else toggle = 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
        if (moving_up_r) begin
          pos_nxt = pos_ext + 1'b1 - (IW+1)'(qrmpw_pkg::SIDE);
          row_nxt = row_r - 1'b1;
        end else begin
          pos_nxt = pos_ext + 1'b1 + (IW+1)'(qrmpw_pkg::SIDE);
          row_nxt = row_r + 1'b1;
        end
        if (pos_nxt >= (IW+1)'(qrmpw_pkg::CELLS)) step_fail = 1'b1;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      moving_up_r <= 1'b1;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.advance && !sts.stop && toggle) moving_up_r <= !moving_up_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos_r   <= in_module_index;
      row_r   <= RW'(prod >> qrmpw_pkg::DIV_SHIFT);
      steps_r <= '0;
    end else if (cmd.prep) begin
      col_r <= CW'(pos_r - IW'(IW'(row_r) * IW'(qrmpw_pkg::SIDE)));
    end else if (cmd.advance && !sts.stop) begin
      pos_r   <= pos_nxt[IW-1:0];
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      steps_r <= steps_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_idx_r <= cmd.found ? pos_r : '0;
      res_nf_r  <= !cmd.found;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_free_index = res_idx_r;
  assign out_no_free    = res_nf_r;

  always_comb begin
    sts.clr_last  = clr_cnt_r == IW'(qrmpw_pkg::CELLS - 1);
    sts.find_ok   = (in_operation == qrmpw_pkg::OP_FIND) && in_range;
    sts.find_bad  = (in_operation == qrmpw_pkg::OP_FIND) && !in_range;
    sts.free      = !rd_data_r;
    sts.stop      = steps_r >= SW'(qrmpw_pkg::MAX_STEPS) || step_fail;
    sts.slot_free = !out_valid_r || out_ready;
  end

endmodule

// File: rtl/qrmpw_checker.sv
// ----------------------------------------------------------------------------
// qrmpw_checker
// Port-level checks of the walker, bound to the top level.
// ----------------------------------------------------------------------------
module qrmpw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [qrmpw_pkg::IDX_W-1:0] out_free_index,
  input logic                        out_no_free
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_free_index) && $stable(out_no_free))
    else $error("result word changed while stalled");

  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == qrmpw_pkg::OP_FIND |=> !in_ready)
    else $error("input ready while a find is in progress");

  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_free |-> out_free_index == '0)
    else $error("no_free result with nonzero index");

endmodule

bind qr_module_placement_walker_unit qrmpw_checker u_qrmpw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_operation   (in_chan.operation),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_free_index (out_chan.free_index),
  .out_no_free    (out_chan.no_free)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the qr module placement walker against its own zigzag predictor.
// Write and find words go in through bursty traffic, and a stalling receiver
// takes the results. Each found index and no-free flag is compared with the
// predicted value. The tests cover the field extremes, the column 6 skip and
// the end of the walk, full-map walks and long result backpressure. Most of
// the random words reserve zigzag runs and then search across them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 640;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int MAX_REPORTS  = 20;

  typedef struct packed {
    logic [qrmpw_pkg::IDX_W-1:0] free_index;
    logic                        no_free;
  } find_result_t;

  logic clk = 1'b0;
  logic rst_n;

  qrmpw_in_if  in_chan ();
  qrmpw_out_if out_chan ();

  qr_module_placement_walker_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bit           occ_map [qrmpw_pkg::CELLS];
  bit           walk_up;
  find_result_t pending_finds [$];
  find_result_t expected_find;
  int           trail_q [$];

  int errors          = 0;
  int cycle_count     = 0;
  int words_sent      = 0;
  int finds_checked   = 0;
  int no_free_seen    = 0;
  int longest_walk    = 0;
  int in_stall_cycles = 0;
  int burst_left      = 0;
  int rx_phase        = 0;
  int rx_mode         = 0;
  int hold_left       = 0;
  bit hold_req        = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("qr_module_placement_walker_unit test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // one placement step; returns 0 when the walk leaves the symbol
  function automatic bit zigzag_next(inout int pos, inout bit up);
    int col;
    int row;
    bit left_col;
    col = pos % qrmpw_pkg::SIDE;
    row = pos / qrmpw_pkg::SIDE;
    left_col = col[0] != (col < qrmpw_pkg::STRIP_COL);
    if (col == qrmpw_pkg::TIMING_COL || !left_col) begin
      pos = pos - 1;
      return 1'b1;
    end
    if ((row == 0 && up) || (row == qrmpw_pkg::SIDE - 1 && !up)) begin
      if (col == 0)
        return 1'b0;
      pos = pos - 1;
      up = !up;
      return 1'b1;
    end
    pos = up ? pos + 1 - qrmpw_pkg::SIDE : pos + 1 + qrmpw_pkg::SIDE;
    return pos >= 0 && pos < qrmpw_pkg::CELLS;
  endfunction

  function automatic find_result_t predict_find(input int idx);
    find_result_t r;
    int pos;
    int steps;
    r.free_index = '0;
    r.no_free = 1'b1;
    if (idx >= qrmpw_pkg::CELLS)
      return r;
    pos = idx;
    steps = 0;
    while (occ_map[pos]) begin
      if (steps >= qrmpw_pkg::MAX_STEPS)
        return r;
      steps++;
      if (steps > longest_walk)
        longest_walk = steps;
      if (!zigzag_next(pos, walk_up))
        return r;
    end
    r.free_index = pos[qrmpw_pkg::IDX_W-1:0];
    r.no_free = 1'b0;
    return r;
  endfunction

  // modules the walk from start would pass, direction flag left untouched
  function automatic void trace_zigzag(input int start, input int count);
    int pos;
    bit up;
    pos = start;
    up = walk_up;
    trail_q.delete();
    trail_q.push_back(pos);
    repeat (count) begin
      if (!zigzag_next(pos, up))
        break;
      trail_q.push_back(pos);
    end
  endfunction

  task automatic send_word(input logic op, input int idx, input logic val);
    @(negedge clk);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_chan.valid        <= 1'b1;
    in_chan.operation    <= op;
    in_chan.module_index <= idx[qrmpw_pkg::IDX_W-1:0];
    in_chan.module_value <= val;
    do begin
      @(posedge clk);
      if (in_chan.ready !== 1'b1)
        in_stall_cycles++;
    end while (in_chan.ready !== 1'b1);
    words_sent++;
    if (op == qrmpw_pkg::OP_WRITE) begin
      if (idx < qrmpw_pkg::CELLS)
        occ_map[idx] = val;
    end else begin
      pending_finds.push_back(predict_find(idx));
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_finds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    rx_phase++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rx_phase % 64 == 0)
      rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom_range(0, 1));
        2: out_chan.ready <= ($urandom_range(0, 4) != 0);
        default: out_chan.ready <= (rx_phase % 4 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_finds.size() == 0) begin
        report_mismatch("result word with no find pending");
      end else begin
        expected_find = pending_finds.pop_front();
        finds_checked++;
        if (expected_find.no_free)
          no_free_seen++;
        if (out_chan.free_index !== expected_find.free_index)
          report_mismatch($sformatf("free_index %0d, expected %0d",
                                    out_chan.free_index, expected_find.free_index));
        if (out_chan.no_free !== expected_find.no_free)
          report_mismatch($sformatf("no_free %0b, expected %0b",
                                    out_chan.no_free, expected_find.no_free));
      end
    end
  end

  task automatic test_directed();
    send_word(qrmpw_pkg::OP_FIND, 0, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS - 1, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, 511, 1'b1);
    send_word(qrmpw_pkg::OP_WRITE, 511, 1'b1);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::CELLS, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, 256, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, 255, 1'b1);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::CELLS - 1, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS - 1, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::CELLS - 2, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS - 1, 1'b1);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::TIMING_COL, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::TIMING_COL, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, 0, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, 0, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::CELLS - 1, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::CELLS - 2, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, qrmpw_pkg::TIMING_COL, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, 0, 1'b0);
    send_word(qrmpw_pkg::OP_WRITE, 510, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, 0, 1'b1);
  endtask

  task automatic test_backpressure();
    burst_left = 100;
    hold_req = 1'b1;
    repeat (24)
      send_word(qrmpw_pkg::OP_FIND, $urandom_range(0, qrmpw_pkg::CELLS - 1),
                1'($urandom_range(0, 1)));
  endtask

  task automatic test_full_map();
    int m;
    for (int i = 0; i < qrmpw_pkg::CELLS; i++)
      send_word(qrmpw_pkg::OP_WRITE, i, 1'b1);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS - 1, 1'b0);
    repeat (3) send_word(qrmpw_pkg::OP_FIND, $urandom_range(0, qrmpw_pkg::CELLS - 1), 1'b1);
    m = $urandom_range(0, qrmpw_pkg::CELLS - 1);
    send_word(qrmpw_pkg::OP_WRITE, m, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, qrmpw_pkg::CELLS - 1, 1'b0);
    send_word(qrmpw_pkg::OP_FIND, $urandom_range(0, qrmpw_pkg::CELLS - 1), 1'b0);
    for (int i = 0; i < qrmpw_pkg::CELLS; i++)
      send_word(qrmpw_pkg::OP_WRITE, i, 1'b0);
  endtask

  task automatic test_random_zigzag();
    int counted;
    int kind;
    int start;
    int count;
    int pick;
    int idx;
    logic op;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      start = $urandom_range(0, qrmpw_pkg::CELLS - 1);
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 250) : $urandom_range(0, 30);
      if (kind <= 6) begin
        trace_zigzag(start, count);
        foreach (trail_q[i])
          send_word(qrmpw_pkg::OP_WRITE, trail_q[i], 1'b1);
        send_word(qrmpw_pkg::OP_FIND, start, 1'($urandom_range(0, 1)));
        counted += trail_q.size() + 1;
        if ($urandom_range(0, 2) != 0) begin
          foreach (trail_q[i])
            send_word(qrmpw_pkg::OP_WRITE, trail_q[i], 1'b0);
          counted += trail_q.size();
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 8)) begin
          op = 1'($urandom_range(0, 1));
          idx = $urandom_range(0, 511);
          send_word(op, idx, 1'($urandom_range(0, 1)));
          if (op == qrmpw_pkg::OP_FIND || idx < qrmpw_pkg::CELLS)
            counted++;
        end
      end else if (kind == 8) begin
        trace_zigzag(start, count + 2);
        pick = $urandom_range(0, trail_q.size() - 1);
        foreach (trail_q[i])
          send_word(qrmpw_pkg::OP_WRITE, trail_q[i], i != pick);
        send_word(qrmpw_pkg::OP_FIND, trail_q[$urandom_range(0, trail_q.size() - 1)], 1'b0);
        counted += trail_q.size() + 1;
        if ($urandom_range(0, 1) != 0) begin
          foreach (trail_q[i])
            send_word(qrmpw_pkg::OP_WRITE, trail_q[i], 1'b0);
          counted += trail_q.size();
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = 1'($urandom_range(0, 1));
          send_word(op, $urandom_range(qrmpw_pkg::CELLS, 511), 1'($urandom_range(0, 1)));
          if (op == qrmpw_pkg::OP_FIND)
            counted++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.operation = qrmpw_pkg::OP_WRITE;
    in_chan.module_index = '0;
    in_chan.module_value = 1'b0;
    out_chan.ready = 1'b0;
    foreach (occ_map[i])
      occ_map[i] = 1'b0;
    walk_up = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    go_quiet();
    test_backpressure();
    go_quiet();
    test_full_map();
    go_quiet();
    test_random_zigzag();
    go_quiet();

    $display("sent %0d words; checked %0d find results, %0d of them with no free module",
             words_sent, finds_checked, no_free_seen);
    $display("longest zigzag walk %0d steps; input held off %0d cycles",
             longest_walk, in_stall_cycles);
    if (errors == 0)
      $display("qr_module_placement_walker_unit test passed");
    else
      $display("qr_module_placement_walker_unit test failed");
    $finish;
  end

endmodule
